/* src/tdpt_pkg.sv */
`timescale 1ns / 1ps

package tdpt_pkg;

  // Width of the value fields on both channels.
  localparam int unsigned FieldWidth = 32;

  // Operation codes.
  localparam logic OpTest = 1'b0;
  localparam logic OpNext = 1'b1;

  // One input beat.
  typedef struct packed {
    logic                  operation;
    logic [FieldWidth-1:0] value;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic                  is_prime;
    logic [FieldWidth-1:0] prime_value;
    logic                  overflow;
  } out_t;

  // Status of the remainder unit toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_status_t;

endpackage

/* src/tdpt_rem.sv */
`timescale 1ns / 1ps

module tdpt_rem
  import tdpt_pkg::*;
#(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width-1:0] divisor_i,
  output rem_status_t      status_o
);

  localparam int unsigned CntWidth = $clog2(Width + 1);

  logic [Width-1:0]    n_q, n_d;
  logic [Width-1:0]    r_q, r_d;
  logic [Width-1:0]    d_q, d_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [Width:0]      r_shift;
  logic [Width:0]      r_sub;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign r_shift = {r_q, n_q[Width-1]};
  assign r_sub   = r_shift - {1'b0, d_q};

  always_comb begin
    n_d    = n_q;
    r_d    = r_q;
    d_d    = d_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = dividend_i;
      r_d    = '0;
      d_d    = divisor_i;
      cnt_d  = CntWidth'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[Width-2:0], 1'b0};
      if (r_shift >= {1'b0, d_q}) begin
        r_d = r_sub[Width-1:0];
      end else begin
        r_d = r_shift[Width-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state resets; the data path does not need to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.zero = (r_q == '0);

  // The step counter is nonzero exactly while a division runs.
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (cnt_q != '0))
    else $error("remainder counter and busy flag disagree");

  // A finished division leaves the unit idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("remainder done while still busy");

  // A start is never issued on top of a running division.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("remainder unit restarted while busy");

endmodule

/* src/trial_division_prime_test.sv */
`timescale 1ns / 1ps

// Trial-division prime tester. A test beat reports whether value is prime; a next
// beat searches upward from value to the first prime and returns it, or flags
// overflow when none exists up to the largest VALUE_WIDTH-bit value. One input
// beat is taken at a time and gives one result beat. Odd divisors are tried in turn
// by the bit-serial remainder unit, which retires one quotient bit per cycle, and a
// search repeats the test for every candidate it visits. A new beat is taken while
// the previous result still waits in the output register.
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned W = VALUE_WIDTH;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CAND  = 6'b000010,
    ST_BOUND = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_VERD  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  state_e        st_q, st_d;
  logic          op_q, op_d;
  logic [W-1:0]  c_q, c_d;
  logic [W-1:0]  d_q, d_d;
  logic [W+1:0]  sq_q, sq_d;
  logic          verdict_q, verdict_d;
  logic          res_prime_q, res_prime_d;
  logic [W-1:0]  res_val_q, res_val_d;
  logic          res_ovf_q, res_ovf_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;
  logic          in_accept;
  logic          out_free;
  logic          rem_start;
  rem_status_t   rem_st;
  logic [W+31:0] in_ext;
  logic [W+31:0] out_ext;

  // Only the low VALUE_WIDTH bits of the input value take part.
  assign in_ext    = {{W{1'b0}}, in_data_i.value};
  assign out_ext   = {32'b0, res_val_q};
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rem_start = (st_q == ST_BOUND) && (sq_q <= {2'b00, c_q});

  tdpt_rem #(
    .Width(W)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(c_q),
    .divisor_i (d_q),
    .status_o  (rem_st)
  );

  // Sequencer over candidates and odd divisors.
  always_comb begin
    st_d        = st_q;
    op_d        = op_q;
    c_d         = c_q;
    d_d         = d_q;
    sq_d        = sq_q;
    verdict_d   = verdict_q;
    res_prime_d = res_prime_q;
    res_val_d   = res_val_q;
    res_ovf_d   = res_ovf_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d = in_data_i.operation;
          c_d  = in_ext[W-1:0];
          st_d = ST_CAND;
        end
      end
      ST_CAND: begin
        // Small and even candidates are settled at once.
        if (c_q < W'(2)) begin
          verdict_d = 1'b0;
          st_d      = ST_VERD;
        end else if (c_q == W'(2)) begin
          verdict_d = 1'b1;
          st_d      = ST_VERD;
        end else if (!c_q[0]) begin
          verdict_d = 1'b0;
          st_d      = ST_VERD;
        end else begin
          d_d  = W'(3);
          sq_d = (W + 2)'(9);
          st_d = ST_BOUND;
        end
      end
      ST_BOUND: begin
        // Once the divisor squared passes the candidate, it is prime.
        if (rem_start) begin
          st_d = ST_DIV;
        end else begin
          verdict_d = 1'b1;
          st_d      = ST_VERD;
        end
      end
      ST_DIV: begin
        if (rem_st.done) begin
          if (rem_st.zero) begin
            verdict_d = 1'b0;
            st_d      = ST_VERD;
          end else begin
            // (d + 2)^2 = d^2 + 4d + 4
            sq_d = sq_q + {d_q, 2'b00} + (W + 2)'(4);
            d_d  = d_q + W'(2);
            st_d = ST_BOUND;
          end
        end
      end
      ST_VERD: begin
        if ((op_q == OpTest) || verdict_q) begin
          res_prime_d = verdict_q;
          res_val_d   = c_q;
          res_ovf_d   = 1'b0;
          st_d        = ST_FIN;
        end else if (c_q == '1) begin
          res_prime_d = 1'b0;
          res_val_d   = '0;
          res_ovf_d   = 1'b1;
          st_d        = ST_FIN;
        end else begin
          c_d  = c_q + 1'b1;
          st_d = ST_CAND;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Output register: loads the result once the slot is free.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((st_q == ST_FIN) && out_free) begin
      out_valid_d       = 1'b1;
      out_d.is_prime    = res_prime_q;
      out_d.prime_value = out_ext[31:0];
      out_d.overflow    = res_ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    c_q         <= c_d;
    d_q         <= d_d;
    sq_q        <= sq_d;
    verdict_q   <= verdict_d;
    res_prime_q <= res_prime_d;
    res_val_q   <= res_val_d;
    res_ovf_q   <= res_ovf_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted beat starts work on its first candidate.
  a_accept_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (st_q == ST_CAND))
    else $error("accepted beat did not start a candidate");

  // The remainder unit reports only while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_st.done |-> (st_q == ST_DIV))
    else $error("remainder finished outside the divide state");

  // An overflow result carries no prime.
  a_ovf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overflow) |->
      (!out_data_o.is_prime && (out_data_o.prime_value == '0)))
    else $error("overflow result carries a prime");

  // Leaving the final state always fills the output register.
  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_FIN) && out_free) |=> out_valid_q)
    else $error("result was not loaded into the output register");

endmodule
